### sv/crm_pkg.sv
`timescale 1ns / 1ps
// crm_pkg: shared types, codes and defaults of the controller range mapper
// used by crm_ctrl, crm_dp and controller_range_mapper_top; no dependencies
package crm_pkg;

    localparam int CONTROLLERS_DEF = 128;
    localparam int SLOTS_DEF       = 8;
    localparam int TARGETS_DEF     = 64;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 32;
    localparam int COUNT_W    = 11;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_RM  = 2'd1;
    localparam logic [1:0] CMD_EVT = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DUP      = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic       valid;
        logic [6:0] in_lo;
        logic [6:0] in_hi;
        logic [7:0] out_lo;
        logic [7:0] out_hi;
        logic [5:0] target;
    } t_entry;

    typedef struct packed {
        logic       load;
        logic       rd;
        logic       idx_clr;
        logic       idx_inc;
        logic       seen_inc;
        logic       note;
        logic       clr_wr;
        logic       add_wr;
        logic       rm_wr;
        logic       div_start;
        logic       div_step;
        logic       pend_load;
        logic       emit;
        logic       e_map;
        logic       e_last;
        logic [1:0] e_st;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       rd_valid;
        logic       rd_hit;
        logic       dup;
        logic       have_empty;
        logic       have_pend;
        logic       idx_last_slot;
        logic       idx_last_all;
        logic       ctrl_oob;
        logic       tgt_oob;
        logic       ord_oob;
        logic       need_div;
        logic       div_done;
        logic       out_free;
    } t_dp_sts;

endpackage

### sv/crm_dp.sv
`timescale 1ns / 1ps
// crm_dp: mapping table memory, scan counters, serial divider and output register
// depends on crm_pkg
module crm_dp #(
    parameter int CONTROLLERS = crm_pkg::CONTROLLERS_DEF,
    parameter int SLOTS       = crm_pkg::SLOTS_DEF,
    parameter int TARGETS     = crm_pkg::TARGETS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  crm_pkg::t_dp_cmd                i_cmd,
    output crm_pkg::t_dp_sts                o_sts,
    input  logic [crm_pkg::IN_DATA_W-1:0]   i_tdata,
    input  logic [1:0]                      i_tuser,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic [crm_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic                            o_m_tuser,
    output logic                            o_m_tlast
);

    localparam int DEPTH = CONTROLLERS * SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);
    localparam int COUNT_W_LOC = crm_pkg::COUNT_W;

    crm_pkg::t_entry mem [DEPTH];
    crm_pkg::t_entry r_rd;

    logic [1:0]  r_cmd;
    logic [6:0]  r_ctrl, r_val, r_in_lo, r_in_hi;
    logic [5:0]  r_tgt;
    logic [7:0]  r_out_lo, r_out_hi;
    logic [9:0]  r_ord;

    logic [AW-1:0]   r_idx, r_empty_addr;
    logic [CNTW-1:0] r_seen, r_count;
    logic            r_dup, r_have_empty, r_pend_vld;
    logic [5:0]      r_pt;
    logic [7:0]      r_pv;

    logic [31:0] r_num, r_quo;
    logic [7:0]  r_den, r_rem;
    logic [5:0]  r_dcnt;

    logic            r_o_valid, r_o_map, r_o_last;
    logic [1:0]      r_o_st;
    logic [5:0]      r_o_tgt;
    logic [7:0]      r_o_val;
    logic [COUNT_W_LOC-1:0] r_o_cnt;

    logic [AW-1:0]        base, rd_addr, wr_addr;
    logic                 wr_en;
    crm_pkg::t_entry      wr_data, new_ent;
    logic [6:0]           d;
    logic signed [9:0]    diff;
    logic signed [17:0]   prod;
    logic [9:0]           trial;
    logic [7:0]           pend_val;
    logic                 out_free;

    assign base    = AW'(32'(r_ctrl) * SLOTS);
    assign rd_addr = (r_cmd == crm_pkg::CMD_RM) ? r_idx : AW'(base + r_idx);

    assign new_ent = '{valid: 1'b1, in_lo: r_in_lo, in_hi: r_in_hi, out_lo: r_out_lo,
                       out_hi: r_out_hi, target: r_tgt};

    always_comb begin
        wr_en   = i_cmd.clr_wr | i_cmd.add_wr | i_cmd.rm_wr;
        wr_addr = i_cmd.add_wr ? r_empty_addr : r_idx;
        wr_data = i_cmd.add_wr ? new_ent : '0;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd <= mem[rd_addr];
        end
    end

    // mapping arithmetic
    assign d     = r_val - r_rd.in_lo;
    assign diff  = $signed({2'b00, r_rd.out_hi}) - $signed({2'b00, r_rd.out_lo}) + 10'sd1;
    assign prod  = $signed({1'b0, d}) * diff;
    assign trial = {1'b0, r_rem, r_num[31]} - {2'b00, r_den};
    assign pend_val = o_sts.need_div ? r_rd.out_lo + r_quo[7:0]
                    : ((r_val <= r_rd.in_lo) ? r_rd.out_lo : r_rd.out_hi);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= i_tuser;
            r_ctrl   <= i_tdata[6:0];
            r_val    <= i_tdata[13:7];
            r_in_lo  <= i_tdata[20:14];
            r_in_hi  <= i_tdata[27:21];
            r_tgt    <= i_tdata[33:28];
            r_out_lo <= i_tdata[41:34];
            r_out_hi <= i_tdata[49:42];
            r_ord    <= i_tdata[59:50];
        end
        if (i_cmd.note) begin
            if (r_rd.valid && r_rd.target == r_tgt) begin
                r_dup <= 1'b1;
            end
            if (!r_rd.valid && !r_have_empty) begin
                r_have_empty <= 1'b1;
                r_empty_addr <= rd_addr;
            end
        end
        if (i_cmd.load) begin
            r_dup        <= 1'b0;
            r_have_empty <= 1'b0;
            r_pend_vld   <= 1'b0;
            r_seen       <= '0;
        end
        if (i_cmd.seen_inc) begin
            r_seen <= r_seen + 1'b1;
        end
        if (i_cmd.pend_load) begin
            r_pend_vld <= 1'b1;
            r_pt       <= r_rd.target;
            r_pv       <= pend_val;
        end
        if (i_cmd.div_start) begin
            r_num  <= {{14{prod[17]}}, prod};
            r_den  <= {1'b0, r_rd.in_hi} - {1'b0, r_rd.in_lo} + 8'd1;
            r_rem  <= '0;
            r_dcnt <= 6'd32;
        end else if (i_cmd.div_step) begin
            r_num  <= {r_num[30:0], 1'b0};
            r_quo  <= {r_quo[30:0], !trial[9]};
            r_rem  <= trial[9] ? {r_rem[6:0], r_num[31]} : trial[7:0];
            r_dcnt <= r_dcnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.idx_clr || i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.add_wr) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.rm_wr) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_map  <= i_cmd.e_map;
            r_o_last <= i_cmd.e_last;
            r_o_st   <= i_cmd.e_st;
            r_o_tgt  <= i_cmd.e_map ? r_pt : 6'd0;
            r_o_val  <= i_cmd.e_map ? r_pv : 8'd0;
            r_o_cnt  <= COUNT_W_LOC'(r_count);
        end
    end

    assign out_free = !r_o_valid || i_m_tready;

    always_comb begin
        o_sts.cmd           = r_cmd;
        o_sts.rd_valid      = r_rd.valid;
        o_sts.rd_hit        = 32'(r_seen) == 32'(r_ord);
        o_sts.dup           = r_dup;
        o_sts.have_empty    = r_have_empty;
        o_sts.have_pend     = r_pend_vld;
        o_sts.idx_last_slot = r_idx == AW'(SLOTS - 1);
        o_sts.idx_last_all  = r_idx == AW'(DEPTH - 1);
        o_sts.ctrl_oob      = 32'(r_ctrl) >= CONTROLLERS;
        o_sts.tgt_oob       = 32'(r_tgt) >= TARGETS;
        o_sts.ord_oob       = 32'(r_ord) >= 32'(r_count);
        o_sts.need_div      = (r_val > r_rd.in_lo) && (r_val < r_rd.in_hi);
        o_sts.div_done      = r_dcnt == 6'd0;
        o_sts.out_free      = out_free;
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {5'd0, r_o_cnt, r_o_val, r_o_tgt, r_o_st};
    assign o_m_tuser  = r_o_map;
    assign o_m_tlast  = r_o_last;

endmodule

### sv/crm_ctrl.sv
`timescale 1ns / 1ps
// crm_ctrl: sequencer for clearing, add, remove and controller event walks
// depends on crm_pkg; drives crm_dp through command and status structs
module crm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output crm_pkg::t_dp_cmd o_cmd,
    input  crm_pkg::t_dp_sts i_sts
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_MAP  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_AEND = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    logic [3:0] r_state, n_state, r_after, n_after;
    logic       r_e_map, n_e_map, r_e_last, n_e_last;
    logic [1:0] r_e_st, n_e_st;
    logic       go_emit, g_map, g_last, fin;
    logic [1:0] g_st;
    logic [3:0] g_after;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_after  <= S_IDLE;
            r_e_map  <= 1'b0;
            r_e_last <= 1'b0;
            r_e_st   <= crm_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_after  <= n_after;
            r_e_map  <= n_e_map;
            r_e_last <= n_e_last;
            r_e_st   <= n_e_st;
        end
    end

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        go_emit    = 1'b0;
        g_map      = 1'b0;
        g_last     = 1'b1;
        g_st       = crm_pkg::ST_OK;
        g_after    = S_IDLE;
        fin        = 1'b0;
        o_s_tready = r_state == S_IDLE;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.idx_last_all) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                case (i_sts.cmd)
                    crm_pkg::CMD_ADD: begin
                        if (i_sts.tgt_oob) begin
                            go_emit = 1'b1;
                            g_st = crm_pkg::ST_NOTFOUND;
                        end else if (i_sts.ctrl_oob) begin
                            go_emit = 1'b1;
                            g_st = crm_pkg::ST_FULL;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    crm_pkg::CMD_RM: begin
                        if (i_sts.ord_oob) begin
                            go_emit = 1'b1;
                            g_st = crm_pkg::ST_NOTFOUND;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    crm_pkg::CMD_EVT: begin
                        if (i_sts.ctrl_oob) begin
                            go_emit = 1'b1;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        go_emit = 1'b1;
                        g_st = crm_pkg::ST_NOTFOUND;
                    end
                endcase
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                case (i_sts.cmd)
                    crm_pkg::CMD_ADD: begin
                        o_cmd.note = 1'b1;
                        if (i_sts.idx_last_slot) begin
                            n_state = S_AEND;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                            n_state = S_RD;
                        end
                    end
                    crm_pkg::CMD_RM: begin
                        if (i_sts.rd_valid && i_sts.rd_hit) begin
                            o_cmd.rm_wr = 1'b1;
                            go_emit = 1'b1;
                        end else begin
                            o_cmd.seen_inc = i_sts.rd_valid;
                            if (i_sts.idx_last_all) begin
                                go_emit = 1'b1;
                                g_st = crm_pkg::ST_NOTFOUND;
                            end else begin
                                o_cmd.idx_inc = 1'b1;
                                n_state = S_RD;
                            end
                        end
                    end
                    default: begin
                        if (i_sts.have_pend) begin
                            go_emit = 1'b1;
                            g_map   = 1'b1;
                            g_last  = !i_sts.rd_valid;
                            g_after = i_sts.rd_valid ? S_MAP : S_IDLE;
                        end else if (!i_sts.rd_valid) begin
                            go_emit = 1'b1;
                        end else begin
                            n_state = S_MAP;
                        end
                    end
                endcase
            end
            S_MAP: begin
                if (i_sts.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    fin = 1'b1;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    fin = 1'b1;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_AEND: begin
                go_emit = 1'b1;
                if (i_sts.dup) begin
                    g_st = crm_pkg::ST_DUP;
                end else if (i_sts.have_empty) begin
                    o_cmd.add_wr = 1'b1;
                end else begin
                    g_st = crm_pkg::ST_FULL;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = r_after;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // slot mapped: hold it, then look at the next slot or close the walk
        if (fin) begin
            o_cmd.pend_load = 1'b1;
            if (i_sts.idx_last_slot) begin
                go_emit = 1'b1;
                g_map   = 1'b1;
            end else begin
                o_cmd.idx_inc = 1'b1;
                n_state = S_RD;
            end
        end

        o_cmd.e_map  = r_e_map;
        o_cmd.e_last = r_e_last;
        o_cmd.e_st   = r_e_st;
        n_after  = r_after;
        n_e_map  = r_e_map;
        n_e_last = r_e_last;
        n_e_st   = r_e_st;
        if (go_emit) begin
            n_state  = S_EMIT;
            n_after  = g_after;
            n_e_map  = g_map;
            n_e_last = g_last;
            n_e_st   = g_st;
        end
    end

endmodule

### sv/controller_range_mapper_top.sv
`timescale 1ns / 1ps
// controller_range_mapper_top: controller range mapper, sequencer plus datapath
// depends on crm_pkg, crm_ctrl, crm_dp
//
// channel | dir | tdata                                          | tuser     | tlast
// s       | in  | ctrl_number, ctrl_value, range_in_low,          | cmd       | -
//         |     | range_in_high, target_id, range_out_low,        |           |
//         |     | range_out_high, entry_ordinal                   |           |
// m       | out | status, out_target, out_value, entry_count      | is_mapped | last
//
// after reset the table memory is cleared, one entry a cycle, all CONTROLLERS*SLOTS entries
// add: reads each slot of the controller in turn; event: per slot up to the first empty
// one, a read, a mapping (serial 32-bit divider) and an emit; remove: scans entries one
// by one, up to CONTROLLERS*SLOTS entries, through the single memory read port
// one item at a time; a result waits in the output register, emission stalls on it
module controller_range_mapper_top #(
    parameter int CONTROLLERS = crm_pkg::CONTROLLERS_DEF,
    parameter int SLOTS       = crm_pkg::SLOTS_DEF,
    parameter int TARGETS     = crm_pkg::TARGETS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // ctrl_number, ctrl_value, range_in_low, range_in_high, target_id,
    // range_out_low, range_out_high, entry_ordinal, zero fill
    input  logic [crm_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // cmd
    input  logic [1:0]                     i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // status, out_target, out_value, entry_count, zero fill
    output logic [crm_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // is_mapped
    output logic                           o_m_tuser,
    output logic                           o_m_tlast
);

    crm_pkg::t_dp_cmd cmd;
    crm_pkg::t_dp_sts sts;

    crm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    crm_dp #(
        .CONTROLLERS (CONTROLLERS),
        .SLOTS       (SLOTS),
        .TARGETS     (TARGETS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_tdata    (i_s_tdata),
        .i_tuser    (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded over a waiting result");

    a_add_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.add_wr |-> (!sts.dup && sts.have_empty))
        else $error("add written without a free slot");

    a_map_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[1:0] == crm_pkg::ST_OK))
        else $error("mapped result with error status");

    a_one_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr_wr, cmd.add_wr, cmd.rm_wr}))
        else $error("two table writes at once");

endmodule

### bench/controller_range_mapper_top_tb.sv
`timescale 1ns / 1ps
// controller_range_mapper_top_tb: self-checking bench for the controller range mapper
// drives add, remove and controller event commands and checks every result
// against a table-based predictor; depends on crm_pkg and controller_range_mapper_top
module controller_range_mapper_top_tb;

    localparam int NCTRL = 128;
    localparam int NSLOT = 8;
    localparam int NTGT  = 64;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  target;
        logic [7:0]  value;
        logic        mapped;
        logic        last;
        logic [10:0] count;
    } t_map_res;

    typedef struct {
        logic [1:0] cmd;
        logic [6:0] ctrl;
        logic [6:0] cval;
        logic [6:0] in_lo;
        logic [6:0] in_hi;
        logic [5:0] tgt;
        logic [7:0] out_lo;
        logic [7:0] out_hi;
        logic [9:0] ord;
    } t_map_cmd;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    crm_pkg::t_entry map_tbl [NCTRL*NSLOT];
    int         map_count;
    t_map_res   pending_res[$];
    int         err_count;
    int         hold_cycles;

    controller_range_mapper_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    function automatic logic [7:0] scale_value(input crm_pkg::t_entry e,
                                               input logic [6:0] v);
        logic [31:0] span;
        logic [31:0] num;
        logic [31:0] den;
        if (v <= e.in_lo) return e.out_lo;
        if (v >= e.in_hi) return e.out_hi;
        span = 32'(e.out_hi) - 32'(e.out_lo) + 32'd1;
        num  = 32'(v - e.in_lo) * span;
        den  = 32'(e.in_hi) - 32'(e.in_lo) + 32'd1;
        return 8'(32'(e.out_lo) + num / den);
    endfunction

    function automatic t_map_res status_res(input logic [1:0] st);
        t_map_res r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        r.count = 11'(map_count);
        return r;
    endfunction

    task automatic predict_mapping(input t_map_cmd c);
        logic [1:0] st;
        int         seen;
        int         n;
        t_map_res   r;
        int         base;
        base = int'(c.ctrl) * NSLOT;
        case (c.cmd)
            crm_pkg::CMD_ADD: begin
                st = crm_pkg::ST_FULL;
                if (c.tgt >= NTGT) st = crm_pkg::ST_NOTFOUND;
                else begin
                    for (int i = 0; i < NSLOT; i++)
                        if (map_tbl[base+i].valid && map_tbl[base+i].target == c.tgt)
                            st = crm_pkg::ST_DUP;
                    if (st != crm_pkg::ST_DUP)
                        for (int i = 0; i < NSLOT; i++)
                            if (st == crm_pkg::ST_FULL && !map_tbl[base+i].valid) begin
                                map_tbl[base+i] = '{1'b1, c.in_lo, c.in_hi, c.out_lo,
                                                    c.out_hi, c.tgt};
                                map_count++;
                                st = crm_pkg::ST_OK;
                            end
                end
                pending_res.push_back(status_res(st));
            end
            crm_pkg::CMD_RM: begin
                st = crm_pkg::ST_NOTFOUND;
                seen = 0;
                for (int i = 0; i < NCTRL*NSLOT; i++)
                    if (map_tbl[i].valid && st == crm_pkg::ST_NOTFOUND) begin
                        if (seen == c.ord) begin
                            map_tbl[i].valid = 1'b0;
                            map_count--;
                            st = crm_pkg::ST_OK;
                        end
                        seen++;
                    end
                pending_res.push_back(status_res(st));
            end
            crm_pkg::CMD_EVT: begin
                n = 0;
                for (int i = 0; i < NSLOT; i++) begin
                    if (!map_tbl[base+i].valid) break;
                    r = status_res(crm_pkg::ST_OK);
                    r.target = map_tbl[base+i].target;
                    r.value = scale_value(map_tbl[base+i], c.cval);
                    r.mapped = 1'b1;
                    r.last = 1'b0;
                    pending_res.push_back(r);
                    n++;
                end
                if (n == 0) pending_res.push_back(status_res(crm_pkg::ST_OK));
                else pending_res[$].last = 1'b1;
            end
            default: pending_res.push_back(status_res(crm_pkg::ST_NOTFOUND));
        endcase
    endtask

    task automatic send_item(input t_map_cmd c);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= c.cmd;
        i_s_tdata  <= {4'd0, c.ord, c.out_hi, c.out_lo, c.tgt, c.in_hi, c.in_lo,
                       c.cval, c.ctrl};
        predict_mapping(c);
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // burst/gap pacing around each sent item
    int burst_left;
    task automatic offer_item(input t_map_cmd c);
        if (burst_left == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        send_item(c);
    endtask

    task automatic idle_until_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_res.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_map_cmd rand_cmd(input logic [1:0] op, input logic [6:0] ctrl);
        t_map_cmd c;
        c.cmd = op;
        c.ctrl = ctrl;
        c.cval = 7'($urandom);
        c.in_lo = 7'($urandom);
        c.in_hi = 7'($urandom);
        c.tgt = 6'($urandom_range(0, 15));
        c.out_lo = 8'($urandom);
        c.out_hi = 8'($urandom);
        c.ord = 10'($urandom_range(0, map_count + 2));
        return c;
    endfunction

    task automatic test_directed();
        t_map_cmd c;
        c = rand_cmd(crm_pkg::CMD_RM, 7'd0);
        c.ord = 10'd0;
        offer_item(c);
        c = rand_cmd(crm_pkg::CMD_EVT, 7'd127);
        offer_item(c);
        c = '{crm_pkg::CMD_ADD, 7'd127, 7'd0, 7'd10, 7'd100, 6'd63, 8'd255, 8'd0, 10'h3ff};
        offer_item(c);
        offer_item(c);
        c = '{crm_pkg::CMD_ADD, 7'd127, 7'd0, 7'd0, 7'd127, 6'd0, 8'd0, 8'd255, 10'h000};
        offer_item(c);
        for (int i = 1; i < 8; i++) begin
            c = '{crm_pkg::CMD_ADD, 7'd5, 7'd0, 7'(i), 7'(120 - i), 6'(i), 8'(i*30),
                  8'(200 - i), 10'd0};
            offer_item(c);
        end
        c = '{crm_pkg::CMD_ADD, 7'd5, 7'd0, 7'd1, 7'd120, 6'd42, 8'd1, 8'd2, 10'd0};
        offer_item(c);
        for (int b = 0; b < 7; b++) begin
            c = '{crm_pkg::CMD_EVT, 7'd5, 7'(1 << b), 7'd0, 7'd0, 6'd0, 8'd0, 8'd0, 10'd0};
            offer_item(c);
        end
        c.cval = 7'd127;
        c.ctrl = 7'd127;
        offer_item(c);
        c.cval = 7'd0;
        offer_item(c);
        c = '{2'd3, 7'd0, 7'd0, 7'd0, 7'd0, 6'd0, 8'd0, 8'd0, 10'd0};
        offer_item(c);
        c = '{crm_pkg::CMD_RM, 7'd0, 7'd0, 7'd0, 7'd0, 6'd0, 8'd0, 8'd0, 10'd3};
        offer_item(c);
        idle_until_drained();
    endtask

    task automatic test_random();
        t_map_cmd c;
        logic [1:0] op;
        for (int n = 0; n < 110; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: op = crm_pkg::CMD_ADD;
                4:          op = crm_pkg::CMD_RM;
                9:          op = 2'($urandom);
                default:    op = crm_pkg::CMD_EVT;
            endcase
            c = rand_cmd(op, ($urandom_range(0, 3) == 0) ? 7'($urandom) :
                             7'($urandom_range(0, 3)));
            if ($urandom_range(0, 7) == 0) c.ord = 10'($urandom);
            if ($urandom_range(0, 7) == 0) c.tgt = 6'($urandom);
            offer_item(c);
        end
        idle_until_drained();
    endtask

    // receiver held off while events to controller 5 pile up
    task automatic test_backpressure();
        t_map_cmd c;
        hold_cycles = 400;
        for (int n = 0; n < 6; n++) begin
            c = rand_cmd(crm_pkg::CMD_EVT, 7'd5);
            send_item(c);
        end
        idle_until_drained();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 15) < 11) || ($urandom_range(0, 63) == 0);
        end
    end

    always @(posedge i_clk) begin
        t_map_res want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_res.size() == 0) begin
                report_mismatch("unexpected transaction", o_m_tdata, 0);
            end else begin
                want = pending_res.pop_front();
                if (o_m_tdata[1:0] !== want.status)
                    report_mismatch("status", o_m_tdata[1:0], want.status);
                if (o_m_tdata[7:2] !== want.target)
                    report_mismatch("target", o_m_tdata[7:2], want.target);
                if (o_m_tdata[15:8] !== want.value)
                    report_mismatch("value", o_m_tdata[15:8], want.value);
                if (o_m_tdata[26:16] !== want.count)
                    report_mismatch("count", o_m_tdata[26:16], want.count);
                if (o_m_tdata[31:27] !== 5'd0)
                    report_mismatch("fill", o_m_tdata[31:27], 0);
                if (o_m_tuser !== want.mapped)
                    report_mismatch("is_mapped", o_m_tuser, want.mapped);
                if (o_m_tlast !== want.last)
                    report_mismatch("last", o_m_tlast, want.last);
            end
        end
    end

    initial begin
        #20ms;
        $display("[controller_range_mapper_top] ERROR");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        err_count = 0;
        hold_cycles = 0;
        burst_left = 0;
        map_count = 0;
        foreach (map_tbl[i]) map_tbl[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        repeat (300) @(posedge i_clk);
        if (err_count == 0 && pending_res.size() == 0)
            $display("[controller_range_mapper_top] OK");
        else
            $display("[controller_range_mapper_top] ERROR");
        $finish;
    end
endmodule

### filelist.f
sv/crm_pkg.sv
sv/crm_dp.sv
sv/crm_ctrl.sv
sv/controller_range_mapper_top.sv
bench/controller_range_mapper_top_tb.sv
